[rtl/bmb_pkg.sv]
// Shared constants for the clipped box mean blur: register indexes,
// item kinds and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package bmb_pkg;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 13;
    localparam int PIX_W  = 8;

    localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] REG_HALF_SPAN_X  = 2'd2;
    localparam logic [CFG_IW-1:0] REG_HALF_SPAN_Y  = 2'd3;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

endpackage

[rtl/box_mean_blur_clipped_top.sv]
// Clipped box mean blur over a raster gray frame.
// An output leaves after the word that completes its window: the job is queued, the back end
// makes one store read per window pixel, then one divider step per quotient bit, then loads
// the output register.
// Throughput: one word per cycle while no output is due, else one per output job.
// Reset: sync active low; registers to 1024x768, spans 1; the row store is not cleared.
`timescale 1ns / 1ps

module box_mean_blur_clipped_top #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HALF_SPAN = 7,
    parameter int MAX_HEIGHT    = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [bmb_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [bmb_pkg::CFG_DW-1:0]  cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] pixel_value
    input  logic                        s_tuser,   // [0] kind
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [7:0] mean_value
    output logic                        m_tlast
);
    import bmb_pkg::*;

    localparam int DEPTH = MAX_WIDTH * (2 * MAX_HALF_SPAN + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int DW    = $clog2(2 * MAX_HALF_SPAN + 2);
    localparam int JW    = AW + WW + 2 * DW + 1;

    logic          take;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [PIX_W-1:0] wr_data;
    logic          job_push, job_pop, q_empty, q_full, back_busy;
    logic [JW-1:0] job_in, job_out;

    assign s_tready = q_empty && !back_busy;
    assign take     = s_tvalid && s_tready;

    bmb_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HALF_SPAN (MAX_HALF_SPAN),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .AW            (AW),
        .JW            (JW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_take  (take),
        .item_kind  (s_tuser),
        .item_pixel (s_tdata),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .job_push   (job_push),
        .job_data   (job_in)
    );

    bmb_queue #(
        .W (JW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .pop_data  (job_out),
        .empty     (q_empty),
        .full      (q_full)
    );

    bmb_back #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HALF_SPAN (MAX_HALF_SPAN),
        .AW            (AW),
        .JW            (JW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_valid (!q_empty),
        .job_data  (job_out),
        .job_pop   (job_pop),
        .busy      (back_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_mean    (m_tdata),
        .m_last    (m_tlast)
    );

    // queue never fills: a word is taken only with the queue empty
    logic unused_full;
    assign unused_full = q_full;

endmodule

[rtl/bmb_front.sv]
// Front end: configuration registers, raster position tracking, store write
// requests and window jobs for the back end. Depends on bmb_pkg.
`timescale 1ns / 1ps

module bmb_front #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HALF_SPAN = 7,
    parameter int MAX_HEIGHT    = 4096,
    parameter int AW            = 14,
    parameter int JW            = 36
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [bmb_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [bmb_pkg::CFG_DW-1:0]  cfg_data,
    input  logic                        item_take,
    input  logic                        item_kind,
    input  logic [bmb_pkg::PIX_W-1:0]   item_pixel,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic [bmb_pkg::PIX_W-1:0]   wr_data,
    output logic                        job_push,
    output logic [JW-1:0]               job_data
);
    import bmb_pkg::*;

    localparam int DEPTH = MAX_WIDTH * (2 * MAX_HALF_SPAN + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int SW    = $clog2(MAX_HALF_SPAN + 1);
    localparam int DW    = $clog2(2 * MAX_HALF_SPAN + 2);

    typedef struct packed {
        logic [AW-1:0] start;
        logic [WW-1:0] stride;
        logic [DW-1:0] nrows;
        logic [DW-1:0] ncols;
        logic          last;
    } job_t;

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  spanx_reg;
    logic [2:0]  spany_reg;

    logic [WW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [HW-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [AW-1:0] in_addr_reg, in_addr_next, out_addr_reg, out_addr_next;
    logic          wr_en_reg;
    logic [AW-1:0] wr_addr_reg;
    logic [PIX_W-1:0] wr_data_reg;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [SW-1:0] dx, dy;
    logic          do_write, row_ok, ready, last;
    logic [WW-1:0] in_col_a;
    logic [HW-1:0] in_row_a;
    logic [AW-1:0] in_addr_a;
    logic [HW-1:0] rows_left, need_r;
    logic [WW-1:0] cols_left, need_c;
    logic [SW-1:0] up, down, left, right;
    logic [AW:0]   off, start_wide;
    job_t          job;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(height_reg);
        end
        dx = (32'(spanx_reg) > MAX_HALF_SPAN) ? SW'(MAX_HALF_SPAN) : SW'(spanx_reg);
        dy = (32'(spany_reg) > MAX_HALF_SPAN) ? SW'(MAX_HALF_SPAN) : SW'(spany_reg);
    end

    // input side: store the pixel and advance the write position
    always_comb begin
        do_write  = (item_kind == KIND_PIXEL) && (in_row_reg < h_eff);
        in_col_a  = in_col_reg;
        in_row_a  = in_row_reg;
        in_addr_a = in_addr_reg;
        if (do_write) begin
            if ((WW+1)'(in_col_reg) + 1'b1 >= (WW+1)'(w_eff)) begin
                in_col_a = '0;
                in_row_a = in_row_reg + 1'b1;
            end else begin
                in_col_a = in_col_reg + 1'b1;
            end
            in_addr_a = ((AW+1)'(in_addr_reg) + 1'b1 >= (AW+1)'(DEPTH)) ? '0
                        : in_addr_reg + 1'b1;
        end
    end

    // output side: clipped window around the next output position
    always_comb begin
        row_ok    = out_row_reg < h_eff;
        rows_left = h_eff - 1'b1 - out_row_reg;
        cols_left = w_eff - 1'b1 - out_col_reg;
        down  = (rows_left < HW'(dy)) ? SW'(rows_left) : dy;
        right = (cols_left < WW'(dx)) ? SW'(cols_left) : dx;
        up    = (out_row_reg < HW'(dy)) ? SW'(out_row_reg) : dy;
        left  = (out_col_reg < WW'(dx)) ? SW'(out_col_reg) : dx;
        need_r = out_row_reg + HW'(down);
        need_c = out_col_reg + WW'(right);
        ready  = row_ok && ((need_r < in_row_a) ||
                            ((need_r == in_row_a) && (need_c < in_col_a)));
        last   = (out_row_reg == h_eff - 1'b1) && (out_col_reg == w_eff - 1'b1);
        off    = (AW+1)'(up) * (AW+1)'(w_eff) + (AW+1)'(left);
        start_wide = ((AW+1)'(out_addr_reg) >= off) ? (AW+1)'(out_addr_reg) - off
                     : (AW+1)'(out_addr_reg) + (AW+1)'(DEPTH) - off;
        job.start  = AW'(start_wide);
        job.stride = w_eff;
        job.nrows  = DW'(up) + DW'(down) + 1'b1;
        job.ncols  = DW'(left) + DW'(right) + 1'b1;
        job.last   = last;
    end

    always_comb begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_addr_next  = in_addr_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_addr_next = out_addr_reg;
        if (item_take) begin
            in_col_next  = in_col_a;
            in_row_next  = in_row_a;
            in_addr_next = in_addr_a;
            if (ready) begin
                if (last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    in_addr_next = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    out_addr_next = '0;
                end else begin
                    if ((WW+1)'(out_col_reg) + 1'b1 >= (WW+1)'(w_eff)) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + 1'b1;
                    end else begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                    out_addr_next = ((AW+1)'(out_addr_reg) + 1'b1 >= (AW+1)'(DEPTH))
                                    ? '0 : out_addr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= 11'd1024;
            height_reg   <= 13'd768;
            spanx_reg    <= 3'd1;
            spany_reg    <= 3'd1;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_addr_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_addr_reg <= '0;
            wr_en_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[10:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[12:0];
                REG_HALF_SPAN_X:  spanx_reg  <= cfg_data[2:0];
                REG_HALF_SPAN_Y:  spany_reg  <= cfg_data[2:0];
                default: ;
            endcase
            // abandon the frame in progress
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_addr_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_addr_reg <= '0;
            wr_en_reg    <= 1'b0;
        end else begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_addr_reg  <= in_addr_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_addr_reg <= out_addr_next;
            wr_en_reg    <= item_take && do_write;
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg <= in_addr_reg;
        wr_data_reg <= item_pixel;
    end

    assign wr_en    = wr_en_reg;
    assign wr_addr  = wr_addr_reg;
    assign wr_data  = wr_data_reg;
    assign job_push = item_take && ready;
    assign job_data = job;

endmodule

[rtl/bmb_queue.sv]
// Two-entry job queue between front and back end.
// No dependencies.
`timescale 1ns / 1ps

module bmb_queue #(
    parameter int W = 36
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty,
    output logic         full
);
    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'((push && !full)) - 2'((pop && !empty));
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);

endmodule

[rtl/bmb_back.sv]
// Back end: row store, window sum by one store read per cycle, restoring
// divider for the rounded mean, output register. Depends on bmb_pkg.
`timescale 1ns / 1ps

module bmb_back #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HALF_SPAN = 7,
    parameter int AW            = 14,
    parameter int JW            = 36
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [bmb_pkg::PIX_W-1:0] wr_data,
    input  logic                      job_valid,
    input  logic [JW-1:0]             job_data,
    output logic                      job_pop,
    output logic                      busy,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [bmb_pkg::PIX_W-1:0] m_mean,
    output logic                      m_last
);
    import bmb_pkg::*;

    localparam int DEPTH = MAX_WIDTH * (2 * MAX_HALF_SPAN + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int DW    = $clog2(2 * MAX_HALF_SPAN + 2);
    localparam int CNW   = 2 * DW;
    localparam int SUMW  = PIX_W + CNW;
    localparam int QW    = SUMW + 1;
    localparam int RW    = CNW + 1;
    localparam int KW    = $clog2(QW);

    typedef struct packed {
        logic [AW-1:0] start;
        logic [WW-1:0] stride;
        logic [DW-1:0] nrows;
        logic [DW-1:0] ncols;
        logic          last;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_FLUSH, ST_PREP, ST_DIV, ST_HOLD
    } state_t;

    logic [PIX_W-1:0] store [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    state_t          state_reg;
    job_t            job;
    logic [AW-1:0]   addr_reg, row_base_reg;
    logic [WW-1:0]   stride_reg;
    logic [DW-1:0]   nrows_reg, ncols_reg, r_cnt_reg, c_cnt_reg;
    logic            last_reg, rd_pend_reg;
    logic [SUMW-1:0] sum_reg;
    logic [CNW-1:0]  count_reg;
    logic [QW-1:0]   dvd_reg;
    logic [RW-1:0]   rem_reg;
    logic [KW-1:0]   step_reg;
    logic            out_valid_reg, out_last_reg;
    logic [PIX_W-1:0] out_mean_reg;

    logic [AW:0]     addr_inc, base_inc;
    logic [RW-1:0]   trial;

    assign job = job_t'(job_data);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_addr] <= wr_data;
        end
        rdata_reg <= store[addr_reg];
    end

    always_comb begin
        addr_inc = (AW+1)'(addr_reg) + 1'b1;
        if (addr_inc >= (AW+1)'(DEPTH)) begin
            addr_inc = '0;
        end
        base_inc = (AW+1)'(row_base_reg) + (AW+1)'(stride_reg);
        if (base_inc >= (AW+1)'(DEPTH)) begin
            base_inc = base_inc - (AW+1)'(DEPTH);
        end
        trial = {rem_reg[RW-2:0], dvd_reg[QW-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // in ST_HOLD the output register is reloaded below
            if (out_valid_reg && m_tready && (state_reg != ST_HOLD)) begin
                out_valid_reg <= 1'b0;
            end
            rd_pend_reg <= (state_reg == ST_READ);
            if (rd_pend_reg) begin
                sum_reg <= sum_reg + SUMW'(rdata_reg);
            end
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        addr_reg     <= job.start;
                        row_base_reg <= job.start;
                        stride_reg   <= job.stride;
                        nrows_reg    <= job.nrows;
                        ncols_reg    <= job.ncols;
                        last_reg     <= job.last;
                        count_reg    <= CNW'(job.nrows) * CNW'(job.ncols);
                        r_cnt_reg    <= '0;
                        c_cnt_reg    <= '0;
                        sum_reg      <= '0;
                        state_reg    <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (c_cnt_reg == ncols_reg - 1'b1) begin
                        c_cnt_reg <= '0;
                        if (r_cnt_reg == nrows_reg - 1'b1) begin
                            state_reg <= ST_FLUSH;
                        end else begin
                            r_cnt_reg    <= r_cnt_reg + 1'b1;
                            row_base_reg <= AW'(base_inc);
                            addr_reg     <= AW'(base_inc);
                        end
                    end else begin
                        c_cnt_reg <= c_cnt_reg + 1'b1;
                        addr_reg  <= AW'(addr_inc);
                    end
                end
                ST_FLUSH: begin
                    // last read data lands in the sum this cycle
                    state_reg <= ST_PREP;
                end
                ST_PREP: begin
                    dvd_reg   <= QW'(sum_reg) + QW'(count_reg >> 1);
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (trial >= RW'(count_reg)) begin
                        rem_reg <= trial - RW'(count_reg);
                        dvd_reg <= {dvd_reg[QW-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial;
                        dvd_reg <= {dvd_reg[QW-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == KW'(QW - 1)) begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_mean_reg  <= dvd_reg[PIX_W-1:0];
                        out_last_reg  <= last_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign job_pop  = (state_reg == ST_IDLE) && job_valid;
    assign busy     = (state_reg != ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_mean   = out_mean_reg;
    assign m_last   = out_last_reg;

endmodule

[bench/testbench.sv]
// Self-checking bench for box_mean_blur_clipped_top: directed table, fixed extreme frames, then random frames.
// Depends on bmb_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
    import bmb_pkg::*;

    localparam int MAXW = 1024;
    localparam int MAXH = 4096;
    localparam int MAXS = 7;
    localparam int DEPTH = MAXW * (2 * MAXS + 1);

    typedef struct packed {
        logic       kind;
        logic [7:0] pix;
        logic       has_exp;
        logic [7:0] exp_mean;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] mean;
        logic       last;
    } blur_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic m_tlast;

    box_mean_blur_clipped_top dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

    // predictor state
    logic [7:0] pix_store [DEPTH];
    int unsigned fw, fh, sx, sy;
    int unsigned in_c, in_r, out_c, out_r;
    blur_out_t expected_means[$];
    int errors = 0;
    bit rx_idle_on = 1'b1;
    bit tx_idle_on = 1'b1;
    bit hold_rx = 1'b0;

    function automatic int unsigned eff_dim(int unsigned v, int unsigned mx);
        if (v == 0) return 1;
        return v > mx ? mx : v;
    endfunction

    function automatic int unsigned pos_addr(int unsigned r, int unsigned c, int unsigned w);
        return (r * w + c) % DEPTH;
    endfunction

    task automatic reset_positions();
        in_c = 0; in_r = 0; out_c = 0; out_r = 0;
    endtask

    // advance the predictor by one accepted word
    task automatic predict_mean(input logic kind, input logic [7:0] pix);
        int unsigned w, h, dx, dy, nr, nc, r0, c0, sum, cnt;
        blur_out_t o;
        w = eff_dim(fw, MAXW); h = eff_dim(fh, MAXH);
        dx = sx > MAXS ? MAXS : sx; dy = sy > MAXS ? MAXS : sy;
        if (kind == KIND_PIXEL && in_r < h) begin
            pix_store[pos_addr(in_r, in_c, w)] = pix;
            in_c++;
            if (in_c >= w) begin
                in_c = 0; in_r++;
            end
        end
        if (out_r >= h) return;
        nr = out_r + dy; if (nr > h - 1) nr = h - 1;
        nc = out_c + dx; if (nc > w - 1) nc = w - 1;
        if (!((nr < in_r) || (nr == in_r && nc < in_c))) return;
        r0 = out_r > dy ? out_r - dy : 0;
        c0 = out_c > dx ? out_c - dx : 0;
        sum = 0;
        for (int unsigned r = r0; r <= nr; r++)
            for (int unsigned c = c0; c <= nc; c++)
                sum += pix_store[pos_addr(r, c, w)];
        cnt = (nr - r0 + 1) * (nc - c0 + 1);
        o.mean = 8'((sum + cnt / 2) / cnt);
        o.last = (out_r == h - 1 && out_c == w - 1);
        expected_means.push_back(o);
        out_c++;
        if (out_c >= w) begin
            out_c = 0; out_r++;
        end
        if (out_r >= h) reset_positions();
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input int unsigned val);
        @(negedge aclk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= CFG_DW'(val);
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  fw = val & 11'h7ff;
            REG_FRAME_HEIGHT: fh = val & 13'h1fff;
            REG_HALF_SPAN_X:  sx = val & 3'h7;
            default:          sy = val & 3'h7;
        endcase
        reset_positions();
    endtask

    task automatic send_word(input logic kind, input logic [7:0] pix);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_tvalid <= 1'b1; s_tuser <= kind; s_tdata <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_mean(kind, pix);
        @(negedge aclk);
    endtask

    task automatic settle();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (expected_means.size() != 0 && guard < 200000) begin
            @(negedge aclk); guard++;
        end
        repeat (200) @(negedge aclk);
    endtask

    // one frame: all pixels with random drains between, then drains or surplus pixels until it is flushed
    task automatic run_frame(input int unsigned w, input int unsigned h,
                             input int unsigned dx, input int unsigned dy, input int mode);
        int unsigned n;
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_HALF_SPAN_X, dx);
        write_reg(REG_HALF_SPAN_Y, dy);
        n = eff_dim(w, MAXW) * eff_dim(h, MAXH);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) send_word(KIND_DRAIN, 8'($urandom));
            case (mode)
                0: send_word(KIND_PIXEL, 8'($urandom));
                1: send_word(KIND_PIXEL, $urandom_range(0, 1) ? 8'hff : 8'h00);
                default: send_word(KIND_PIXEL, 8'($urandom_range(120, 135)));
            endcase
        end
        // surplus pixels get dropped but still release outputs
        while (out_r != 0 || out_c != 0)
            send_word($urandom_range(0, 1) ? KIND_DRAIN : KIND_PIXEL, 8'($urandom));
        settle();
    endtask

    // result side: random stalls, a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn || hold_rx) m_tready <= 1'b0;
        else if (rx_idle_on && $urandom_range(0, 4) == 0) m_tready <= 1'b0;
        else m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        blur_out_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_means.size() == 0) begin
                $error("unexpected word: mean_value %0d last_pixel %0b", m_tdata, m_tlast);
                errors++;
            end else begin
                e = expected_means.pop_front();
                if (m_tdata !== e.mean) begin
                    $error("mean_value: expected %0d, got %0d", e.mean, m_tdata);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_pixel: expected %0b, got %0b", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // 3x3 frame, 1x1 window: every mean equals its pixel
    stim_row_t id_rows [] = '{
        '{KIND_PIXEL, 8'h00, 1'b1, 8'h00}, '{KIND_PIXEL, 8'hff, 1'b1, 8'hff},
        '{KIND_DRAIN, 8'h5a, 1'b0, 8'h00}, '{KIND_PIXEL, 8'h01, 1'b1, 8'h01},
        '{KIND_PIXEL, 8'h80, 1'b1, 8'h80}, '{KIND_PIXEL, 8'h7f, 1'b1, 8'h7f},
        '{KIND_PIXEL, 8'haa, 1'b1, 8'haa}, '{KIND_PIXEL, 8'h55, 1'b1, 8'h55},
        '{KIND_PIXEL, 8'hfe, 1'b1, 8'hfe}, '{KIND_PIXEL, 8'h10, 1'b1, 8'h10},
        '{KIND_DRAIN, 8'hff, 1'b0, 8'h00}
    };

    initial begin
        blur_out_t top;
        int unsigned frames;
        for (int i = 0; i < DEPTH; i++) pix_store[i] = '0;
        fw = 1024; fh = 768; sx = 1; sy = 1;
        reset_positions();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: identity window, checked against the typed-in means
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        write_reg(REG_HALF_SPAN_X, 0);
        write_reg(REG_HALF_SPAN_Y, 0);
        foreach (id_rows[i]) begin
            send_word(id_rows[i].kind, id_rows[i].pix);
            if (id_rows[i].has_exp) begin
                top = expected_means[$];
                if (top.mean !== id_rows[i].exp_mean) begin
                    $error("mean_value: expected %0d, got %0d (table)",
                           id_rows[i].exp_mean, top.mean);
                    errors++;
                end
            end
        end
        settle();

        // extremes: 1x1 frame, zero sizes, widest spans, wide single row
        run_frame(1, 1, 7, 7, 1);
        run_frame(0, 0, 0, 0, 0);
        run_frame(5, 4, 7, 7, 1);
        run_frame(40, 1, 7, 0, 0);
        run_frame(2, 13, 0, 7, 1);

        // abandon a frame half way through by a register write
        write_reg(REG_FRAME_WIDTH, 6);
        for (int i = 0; i < 9; i++) send_word(KIND_PIXEL, 8'($urandom));
        settle();
        repeat (200) @(negedge aclk);

        // long receiver hold-off while pixels keep coming
        fork
            begin
                hold_rx = 1'b1;
                repeat (400) @(negedge aclk);
                hold_rx = 1'b0;
            end
            run_frame(8, 6, 2, 1, 0);
        join

        frames = 0;
        while (frames < 32) begin
            if (frames >= 26) begin
                rx_idle_on = 1'b0; tx_idle_on = 1'b0;
            end
            run_frame($urandom_range(1, 6), $urandom_range(1, 5),
                      $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 2));
            frames++;
        end
        run_frame(24, 2, 3, 1, 0);

        if (errors == 0 && expected_means.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
